// ----- rtl/ucs_pkg.sv -----
// Package for the UTF-8 character substitution unit.
// Holds the request codes, the token that travels down the cell chain and
// the UTF-8 helper functions. No dependencies.
package ucs_pkg;

  localparam int CHAR_BYTES = 4;

  localparam logic [1:0] REQ_TEXT  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    TOK_LOOKUP,
    TOK_FLUSH,
    TOK_WRITE,
    TOK_CLEAR
  } tok_kind_t;

  typedef struct packed {
    logic        valid;
    tok_kind_t   kind;
    logic [5:0]  slot;
    logic [31:0] key;
    logic [2:0]  key_len;
    logic        hit;
    logic [63:0] out;
    logic [3:0]  out_len;
  } token_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    if (b inside {[8'h00:8'h7F]}) begin
      len = 3'd1;
    end else if (b inside {[8'hC0:8'hDF]}) begin
      len = 3'd2;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      len = 3'd3;
    end else if (b inside {[8'hF0:8'hF7]}) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  function automatic logic [31:0] key_mask(input logic [2:0] len);
    logic [31:0] m;
    case (len)
      3'd1: m = 32'h0000_00FF;
      3'd2: m = 32'h0000_FFFF;
      3'd3: m = 32'h00FF_FFFF;
      3'd4: m = 32'hFFFF_FFFF;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/utf8_char_substitution_unit.sv -----
// Top level of the UTF-8 character substitution unit.
// Connects the assembler, a chain of table cells and the byte emitter.
// Depends on ucs_pkg, ucs_assembler, ucs_cell and ucs_emitter.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    req_type, text_byte, end_of_text, entry_*
//   out      out_valid / out_ready  out_byte, last_of_run, was_translated
//
// One input word is taken per cycle while the chain advances; a word crosses
// TABLE_ENTRIES cell stages before it reaches the emitter.
// A character sends one byte per cycle while out_ready is high; while its
// bytes drain and another character waits at the chain end, the chain holds.
// Reset clears the slot valid bits and the chain at once; no sweep is needed.
module utf8_char_substitution_unit import ucs_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MAX_OUT_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  input  logic [5:0]  entry_slot,
  input  logic [31:0] entry_key,
  input  logic [2:0]  entry_key_len,
  input  logic [63:0] entry_out,
  input  logic [3:0]  entry_out_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        was_translated
);

  token_t chain [TABLE_ENTRIES+1];
  logic   advance;

  assign in_ready = advance;

  ucs_assembler u_assembler (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .text_byte     (text_byte),
    .end_of_text   (end_of_text),
    .entry_slot    (entry_slot),
    .entry_key     (entry_key),
    .entry_key_len (entry_key_len),
    .entry_out     (entry_out),
    .entry_out_len (entry_out_len),
    .tok           (chain[0])
  );

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ucs_cell #(
      .SLOT_INDEX (i),
      .OUT_BYTES  (MAX_OUT_BYTES)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  ucs_emitter u_emitter (
    .clk            (clk),
    .rst            (rst),
    .tail           (chain[TABLE_ENTRIES]),
    .advance        (advance),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .last_of_run    (last_of_run),
    .was_translated (was_translated)
  );

`ifndef ASSERT_OFF
  a_stall_has_output: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("chain stalled with no byte pending on the output");
`endif

endmodule

// ----- rtl/ucs_assembler.sv -----
// Front end of the UTF-8 character substitution unit.
// Groups text bytes into characters and turns each accepted word into a token
// for the cell chain. Depends on ucs_pkg.
module ucs_assembler import ucs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  input  logic [5:0]  entry_slot,
  input  logic [31:0] entry_key,
  input  logic [2:0]  entry_key_len,
  input  logic [63:0] entry_out,
  input  logic [3:0]  entry_out_len,
  output token_t      tok
);

  logic [31:0] char_buffer;
  logic [1:0]  bytes_held;
  logic [2:0]  bytes_expected;

  logic        accept;
  logic        start;
  logic [31:0] base_buf;
  logic [1:0]  base_held;
  logic [2:0]  expect_len;
  logic [31:0] new_buf;
  logic [2:0]  new_held;
  logic        complete;

  assign accept     = in_valid && in_ready;
  assign start      = (bytes_held == 2'd0);
  assign base_buf   = start ? 32'd0 : char_buffer;
  assign base_held  = start ? 2'd0 : bytes_held;
  assign expect_len = start ? lead_length(text_byte) : bytes_expected;
  assign new_buf    = base_buf | (32'(text_byte) << {base_held, 3'b000});
  assign new_held   = {1'b0, base_held} + 3'd1;
  assign complete   = (new_held >= expect_len);

  always_comb begin
    tok         = '0;
    tok.kind    = TOK_LOOKUP;
    tok.slot    = entry_slot;
    tok.key     = new_buf;
    tok.key_len = new_held;
    tok.out     = entry_out;
    tok.out_len = entry_out_len;
    case (req_type)
      REQ_TEXT: begin
        tok.valid = in_valid && (complete || end_of_text);
        tok.kind  = complete ? TOK_LOOKUP : TOK_FLUSH;
      end
      REQ_WRITE: begin
        tok.valid   = in_valid;
        tok.kind    = TOK_WRITE;
        tok.key     = entry_key;
        tok.key_len = entry_key_len;
      end
      REQ_CLEAR: begin
        tok.valid = in_valid;
        tok.kind  = TOK_CLEAR;
      end
      default: begin
        tok.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_held     <= 2'd0;
      bytes_expected <= 3'd0;
      char_buffer    <= 32'd0;
    end else if (accept && (req_type == REQ_TEXT)) begin
      if (complete || end_of_text) begin
        bytes_held     <= 2'd0;
        bytes_expected <= 3'd0;
        char_buffer    <= 32'd0;
      end else begin
        bytes_held     <= new_held[1:0];
        bytes_expected <= expect_len;
        char_buffer    <= new_buf;
      end
    end
  end

`ifndef ASSERT_OFF
  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == REQ_TEXT) && end_of_text |=> bytes_held == 2'd0)
    else $error("partial character survived end of text");
`endif

endmodule

// ----- rtl/ucs_cell.sv -----
// One table slot of the UTF-8 character substitution unit, with its stage
// of the token chain. Compares lookups against the slot and applies writes
// and clears as tokens pass. Depends on ucs_pkg.
module ucs_cell import ucs_pkg::*; #(
  parameter int SLOT_INDEX = 0,
  parameter int OUT_BYTES  = 8
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  token_t tok_in,
  output token_t tok_out
);

  localparam int OUT_W = 8 * OUT_BYTES;
  localparam int LEN_W = $clog2(OUT_BYTES + 1);

  logic             entry_valid;
  logic [31:0]      entry_key;
  logic [2:0]       entry_key_len;
  logic [OUT_W-1:0] entry_out;
  logic [LEN_W-1:0] entry_out_len;

  token_t           tok_q;
  token_t           tok_next;
  logic             match;
  logic             write_here;
  logic [LEN_W-1:0] sat_len;

  assign match = entry_valid && (tok_in.kind == TOK_LOOKUP) && !tok_in.hit &&
                 (entry_key_len == tok_in.key_len) &&
                 (((entry_key ^ tok_in.key) & key_mask(tok_in.key_len)) == 32'd0);

  assign write_here = tok_in.valid && (tok_in.kind == TOK_WRITE) &&
                      (32'(tok_in.slot) == SLOT_INDEX);

  assign sat_len = (tok_in.out_len > 4'(OUT_BYTES)) ? LEN_W'(OUT_BYTES)
                                                    : tok_in.out_len[LEN_W-1:0];

  always_comb begin
    tok_next = tok_in;
    if (match) begin
      tok_next.hit     = 1'b1;
      tok_next.out     = 64'(entry_out);
      tok_next.out_len = 4'(entry_out_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (advance && tok_in.valid && (tok_in.kind == TOK_CLEAR)) begin
      entry_valid <= 1'b0;
    end else if (advance && write_here) begin
      entry_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && write_here) begin
      entry_key     <= tok_in.key;
      entry_key_len <= tok_in.key_len;
      entry_out     <= tok_in.out[OUT_W-1:0];
      entry_out_len <= sat_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q.valid <= 1'b0;
    end else if (advance) begin
      tok_q <= tok_next;
    end
  end

  assign tok_out = tok_q;

endmodule

// ----- rtl/ucs_emitter.sv -----
// Output stage of the UTF-8 character substitution unit.
// Takes finished tokens from the end of the cell chain and sends their bytes
// one byte at a time; also produces the chain advance. Depends on ucs_pkg.
module ucs_emitter import ucs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  token_t     tail,
  output logic       advance,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       was_translated
);

  logic [63:0] data;
  logic [3:0]  remaining;
  logic        translated;

  logic        needs;
  logic        free;
  logic        load;
  logic [3:0]  load_len;
  logic [63:0] load_data;

  assign load_len  = tail.hit ? tail.out_len : {1'b0, tail.key_len};
  assign load_data = tail.hit ? tail.out : 64'(tail.key);
  assign needs     = tail.valid && ((tail.kind == TOK_LOOKUP) || (tail.kind == TOK_FLUSH)) &&
                     (load_len != 4'd0);
  assign free      = (remaining == 4'd0) || ((remaining == 4'd1) && out_ready);
  assign advance   = !needs || free;
  assign load      = needs && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 4'd0;
    end else if (load) begin
      remaining <= load_len;
    end else if (out_valid && out_ready) begin
      remaining <= remaining - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data       <= load_data;
      translated <= tail.hit;
    end else if (out_valid && out_ready) begin
      data <= {8'd0, data[63:8]};
    end
  end

  assign out_valid      = (remaining != 4'd0);
  assign out_byte       = data[7:0];
  assign last_of_run    = (remaining == 4'd1);
  assign was_translated = translated;

`ifndef ASSERT_OFF
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    load |=> remaining == $past(load_len))
    else $error("byte count not taken from loaded token");
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run && !load |=> out_valid)
    else $error("run ended before its last byte");
`endif

endmodule
